### sv/lin_pkg.sv
`timescale 1ns / 1ps
package lin_pkg;
   localparam int DefaultNumSlots = 4;

   localparam logic [21:0] RstTarget = 22'd7500;
   localparam logic [15:0] RstSlack = 16'd250;
   localparam logic [2:0] RstMaxAttempts = 3'd3;
   localparam logic [2:0] RstMaxReapplies = 3'd5;
   localparam logic [11:0] RstGuard = 12'd3000;
   localparam logic [11:0] RstRetry = 12'd500;
   localparam logic [10:0] UnitsUs = 11'd1250;

   localparam logic [2:0] RegTarget = 3'd0;
   localparam logic [2:0] RegSlack = 3'd1;
   localparam logic [2:0] RegFsEnable = 3'd2;
   localparam logic [2:0] RegMaxAttempts = 3'd3;
   localparam logic [2:0] RegMaxReapplies = 3'd4;
   localparam logic [2:0] RegGuard = 3'd5;
   localparam logic [2:0] RegRetry = 3'd6;

   localparam logic [2:0] OpConnect = 3'd0;
   localparam logic [2:0] OpDisconnect = 3'd1;
   localparam logic [2:0] OpSecurity = 3'd2;
   localparam logic [2:0] OpPhy = 3'd3;
   localparam logic [2:0] OpFsDone = 3'd4;
   localparam logic [2:0] OpRateChanged = 3'd5;
   localparam logic [2:0] OpParam = 3'd6;
   localparam logic [2:0] OpTick = 3'd7;

   localparam logic [2:0] PhIdle = 3'd0;
   localparam logic [2:0] PhFsu = 3'd1;
   localparam logic [2:0] PhRate = 3'd2;
   localparam logic [2:0] PhActive = 3'd3;
   localparam logic [2:0] PhGivenUp = 3'd4;

   localparam logic [1:0] CmdNone = 2'd0;
   localparam logic [1:0] CmdFsu = 2'd1;
   localparam logic [1:0] CmdRate = 2'd2;

   // fields listed from the top bit down, so op lands in bit 0
   typedef struct packed {
      logic        fsu_outcome;
      logic [1:0]  request_outcome;
      logic [11:0] param_interval_units;
      logic [21:0] rate_interval_us;
      logic [1:0]  rate_status;
      logic        link_phy_2m;
      logic        link_secure;
      logic        is_central;
      logic        event_ok;
      logic [11:0] conn_id;
      logic [2:0]  op;
   } req_type;

   typedef struct packed {
      logic [11:0] handle;
      logic        used;
      logic [2:0]  phase;
      logic [2:0]  attempts;
      logic [2:0]  reapplies;
      logic [11:0] countdown;
      logic        armed;
   } slot_type;

   typedef struct packed {
      logic [22:0] limit;
      logic        fs_enable;
      logic [2:0]  max_attempts;
      logic [2:0]  max_reapplies;
      logic [11:0] guard_ms;
      logic [11:0] retry_ms;
   } cfg_type;

   // fields listed from the top bit down, so slot lands in bit 0
   typedef struct packed {
      logic [2:0] reapply_count;
      logic [2:0] attempt_count;
      logic [2:0] phase;
      logic [1:0] command;
      logic       matched;
      logic [1:0] slot;
   } rsp_type;
endpackage

### sv/link_interval_negotiator.sv
`timescale 1ns / 1ps
// Link interval negotiator. Slot state lives in a NUM_SLOTS-entry memory with a registered
// read. One request is handled at a time: after the accept cycle the slots are scanned one
// per cycle. An event that finds or claims a slot then reads that slot again (StRead),
// updates and writes it back (StProc) and offers its response (StOut); an unmatched event
// offers an all-zero response straight after the scan. A tick updates each armed slot
// during the scan and then offers one response per expired slot (at most four, last one
// flagged with tlast), or none. A stalled response holds the block. After reset a clearing
// pass over all slots runs before the first request is taken. Write the registers only
// between requests.
module link_interval_negotiator #(
   parameter int NUM_SLOTS = lin_pkg::DefaultNumSlots
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // op, conn_id, event_ok, is_central, link_secure, link_phy_2m, rate_status,
   // rate_interval_us, param_interval_units, request_outcome, fsu_outcome, zero fill
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // slot, matched, command, phase, attempt_count, reapply_count, zero fill
   output logic [15:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [21:0] csr_wdata
);
   import lin_pkg::*;

   localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CW = $clog2(NUM_SLOTS + 1);

   typedef enum logic [5:0] {
      StClear = 6'b000001, StIdle = 6'b000010, StFind = 6'b000100,
      StRead = 6'b001000, StProc = 6'b010000, StOut = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [21:0] target_ff;
   logic [15:0] slack_ff;
   logic fs_en_ff;
   logic [2:0] max_att_ff, max_reap_ff;
   logic [11:0] guard_ff, retry_ff;
   cfg_type cfg;

   req_type req_ff;
   slot_type mem [NUM_SLOTS];
   slot_type rd_ff;
   logic [SW-1:0] rd_addr;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] hit_ff, hit_in;       // NUM_SLOTS means none
   logic [2:0] nres_ff, nres_in;
   rsp_type res_ff [4];
   rsp_type res_in [4];
   logic [1:0] oidx_ff, oidx_in;
   logic rd_fired;
   logic claim, fired, wr_en;
   slot_type nxt;
   slot_type wr_data;
   logic [SW-1:0] wr_addr;
   logic [1:0] cmd;
   logic [CW-1:0] prev_idx;
   logic [SW-1:0] idx_w;
   logic [SW-1:0] hit_w;
   logic [SW-1:0] prev_w;

   assign idx_w = idx_ff[SW-1:0];
   assign hit_w = hit_ff[SW-1:0];
   // slot whose data sits in rd_ff during the scan
   assign prev_idx = idx_ff - CW'(1);
   assign prev_w = prev_idx[SW-1:0];

   assign cfg.limit = {1'b0, target_ff} + 23'(slack_ff);
   assign cfg.fs_enable = fs_en_ff;
   assign cfg.max_attempts = max_att_ff;
   assign cfg.max_reapplies = max_reap_ff;
   assign cfg.guard_ms = guard_ff;
   assign cfg.retry_ms = retry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= RstTarget;
         slack_ff <= RstSlack;
         fs_en_ff <= 1'b1;
         max_att_ff <= RstMaxAttempts;
         max_reap_ff <= RstMaxReapplies;
         guard_ff <= RstGuard;
         retry_ff <= RstRetry;
      end else if (csr_we) begin
         case (csr_index)
            RegTarget: target_ff <= csr_wdata;
            RegSlack: slack_ff <= csr_wdata[15:0];
            RegFsEnable: fs_en_ff <= csr_wdata[0];
            RegMaxAttempts: max_att_ff <= csr_wdata[2:0];
            RegMaxReapplies: max_reap_ff <= csr_wdata[2:0];
            RegGuard: guard_ff <= csr_wdata[11:0];
            RegRetry: retry_ff <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   assign req_tready = (state_ff == StIdle);
   assign rsp_tvalid = (state_ff == StOut);
   assign rsp_tdata = {2'b0, res_ff[oidx_ff]};
   assign rsp_tlast = ({1'b0, oidx_ff} + 3'd1 == nres_ff);

   // fire decision for tick on the slot just read
   assign rd_fired = rd_ff.armed && (rd_ff.countdown <= 12'd1);
   assign claim = (state_ff == StProc) && (req_ff.op == OpConnect);
   assign fired = (state_ff == StFind) && (req_ff.op == OpTick) && rd_fired;

   lin_slot_update u_upd (
      .cfg(cfg), .req(req_ff), .cur(rd_ff), .claim(claim), .fired(fired),
      .nxt(nxt), .command(cmd)
   );

   // read address: slot 0 on accept, scan index during find, hit slot during read
   always_comb begin
      rd_addr = '0;
      case (state_ff)
         StFind: if (idx_ff != CW'(NUM_SLOTS)) rd_addr = idx_w;
         StRead: rd_addr = hit_w;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[rd_addr];
      if (state_ff == StClear) mem[idx_w] <= '0;
      else if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (state_ff == StIdle && req_tvalid) req_ff <= req_type'(req_tdata[57:0]);
      res_ff <= res_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StClear;
         idx_ff <= '0;
         hit_ff <= CW'(NUM_SLOTS);
         nres_ff <= '0;
         oidx_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         hit_ff <= hit_in;
         nres_ff <= nres_in;
         oidx_ff <= oidx_in;
      end
   end

   always_comb begin
      rsp_type r;
      state_in = state_ff;
      idx_in = idx_ff;
      hit_in = hit_ff;
      nres_in = nres_ff;
      oidx_in = oidx_ff;
      res_in = res_ff;
      wr_en = 1'b0;
      wr_addr = prev_w;
      wr_data = nxt;
      r = '0;
      case (state_ff)
         StClear: begin
            idx_in = idx_ff + CW'(1);
            if (idx_ff == CW'(NUM_SLOTS - 1)) begin
               state_in = StIdle;
            end
         end
         StIdle: begin
            idx_in = '0;
            hit_in = CW'(NUM_SLOTS);
            nres_in = '0;
            oidx_in = '0;
            if (req_tvalid) begin
               state_in = StFind;
               idx_in = CW'(1);
            end
         end
         StFind: begin
            // rd_ff holds slot idx_ff-1; memory address for next cycle is idx_ff
            if (req_ff.op == OpTick) begin
               if (rd_ff.armed) begin
                  wr_en = 1'b1;
                  if (!rd_fired) begin
                     wr_data = rd_ff;
                     wr_data.countdown = rd_ff.countdown - 12'd1;
                  end else if (nres_ff < 3'd4) begin
                     r.slot = 2'(prev_idx);
                     r.matched = 1'b1;
                     r.command = cmd;
                     r.phase = nxt.phase;
                     r.attempt_count = nxt.attempts;
                     r.reapply_count = nxt.reapplies;
                     res_in[nres_ff[1:0]] = r;
                     nres_in = nres_ff + 3'd1;
                  end
               end
            end else if (hit_ff == CW'(NUM_SLOTS)) begin
               if (req_ff.op == OpConnect) begin
                  if (req_ff.event_ok && req_ff.is_central && !rd_ff.used)
                     hit_in = prev_idx;
               end else if (rd_ff.used && rd_ff.handle == req_ff.conn_id) begin
                  hit_in = prev_idx;
               end
            end
            idx_in = idx_ff + CW'(1);
            if (idx_ff == CW'(NUM_SLOTS)) begin
               if (req_ff.op == OpTick) begin
                  state_in = (nres_in == 3'd0) ? StIdle : StOut;
               end else if (hit_in == CW'(NUM_SLOTS)) begin
                  res_in[0] = '0;
                  nres_in = 3'd1;
                  state_in = StOut;
               end else begin
                  state_in = StRead;
               end
            end
         end
         StRead: state_in = StProc;
         StProc: begin
            wr_en = 1'b1;
            wr_addr = hit_w;
            r.slot = 2'(hit_ff);
            r.matched = 1'b1;
            r.command = cmd;
            r.phase = nxt.phase;
            r.attempt_count = nxt.attempts;
            r.reapply_count = nxt.reapplies;
            res_in[0] = r;
            nres_in = 3'd1;
            state_in = StOut;
         end
         StOut: begin
            if (rsp_tready) begin
               if (rsp_tlast) state_in = StIdle;
               else oidx_in = oidx_ff + 2'd1;
            end
         end
         default: ;
      endcase
   end
endmodule

### sv/lin_slot_update.sv
`timescale 1ns / 1ps
// Next state of one slot for one event; purely combinational.
module lin_slot_update (
   input  lin_pkg::cfg_type  cfg,
   input  lin_pkg::req_type  req,
   input  lin_pkg::slot_type cur,
   input  logic              claim,
   input  logic              fired,
   output lin_pkg::slot_type nxt,
   output logic [1:0]        command
);
   import lin_pkg::*;

   logic [2:0] att_inc;
   logic       prod_gt;
   logic [22:0] prod;
   logic       rint_gt;

   assign prod = 23'(req.param_interval_units) * 23'(UnitsUs);
   assign prod_gt = prod > cfg.limit;
   assign rint_gt = {1'b0, req.rate_interval_us} > cfg.limit;
   assign att_inc = (cur.attempts < 3'd7) ? cur.attempts + 3'd1 : cur.attempts;

   always_comb begin
      slot_type s;
      logic do_rate;
      logic do_start;
      logic do_reap;
      s = cur;
      command = CmdNone;
      do_rate = 1'b0;
      do_start = 1'b0;
      do_reap = 1'b0;
      if (claim) begin
         s = '0;
         s.used = 1'b1;
         s.handle = req.conn_id;
      end else if (fired) begin
         s.armed = 1'b0;
         s.countdown = '0;
         if (cur.used) begin
            case (cur.phase)
               PhFsu, PhIdle: do_rate = 1'b1;
               PhRate: begin
                  if (cur.attempts >= cfg.max_attempts) s.phase = PhGivenUp;
                  else do_rate = 1'b1;
               end
               default: ;
            endcase
         end
      end else begin
         case (req.op)
            OpDisconnect: begin
               s.armed = 1'b0;
               s.countdown = '0;
               s.used = 1'b0;
               s.handle = '0;
               s.phase = PhIdle;
            end
            OpSecurity: do_start = req.event_ok && req.link_secure && req.link_phy_2m;
            OpPhy: do_start = req.link_phy_2m && req.link_secure;
            OpFsDone: begin
               if (cur.phase == PhFsu) begin
                  s.armed = 1'b0;
                  s.countdown = '0;
                  do_rate = 1'b1;
               end
            end
            OpRateChanged: begin
               if (req.rate_status == 2'd0) begin
                  s.armed = 1'b0;
                  s.countdown = '0;
                  s.attempts = '0;
                  if (!rint_gt) s.phase = PhActive;
                  else if (cur.phase != PhGivenUp) do_reap = 1'b1;
               end else if (cur.phase == PhRate) begin
                  s.armed = 1'b0;
                  s.countdown = '0;
                  if (req.rate_status == 2'd1 || cur.attempts >= cfg.max_attempts) begin
                     s.phase = PhGivenUp;
                  end else begin
                     s.phase = PhIdle;
                     s.armed = 1'b1;
                     s.countdown = cfg.retry_ms;
                  end
               end
            end
            OpParam: do_reap = (cur.phase == PhActive) && prod_gt;
            default: ;
         endcase
         if (do_start && cur.phase == PhIdle) begin
            if (cfg.fs_enable) begin
               command = CmdFsu;
               if (!req.fsu_outcome) begin
                  s.phase = PhFsu;
                  s.armed = 1'b1;
                  s.countdown = cfg.guard_ms;
               end else do_rate = 1'b1;
            end else do_rate = 1'b1;
         end
      end
      if (do_rate) begin
         s.attempts = att_inc;
         command = CmdRate;
         if (req.request_outcome == 2'd0) begin
            s.phase = PhRate;
            s.armed = 1'b1;
            s.countdown = cfg.guard_ms;
         end else if (req.request_outcome == 2'd1 || att_inc >= cfg.max_attempts) begin
            s.phase = PhGivenUp;
         end else begin
            s.phase = PhIdle;
            s.armed = 1'b1;
            s.countdown = cfg.retry_ms;
         end
      end
      if (do_reap) begin
         if (cur.reapplies >= cfg.max_reapplies) begin
            s.phase = PhGivenUp;
         end else begin
            if (cur.reapplies < 3'd7) s.reapplies = cur.reapplies + 3'd1;
            s.attempts = '0;
            s.phase = PhIdle;
            s.armed = 1'b1;
            s.countdown = cfg.retry_ms;
         end
      end
      nxt = s;
   end
endmodule
